/* rtl/core/simple_tcp_connection_engine_defines.svh */
// Assertion macros used by the checker file.
`ifndef SIMPLE_TCP_CONNECTION_ENGINE_DEFINES_SVH
`define SIMPLE_TCP_CONNECTION_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define STCE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define STCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/stce_pkg.sv */
`timescale 1ns / 1ps

package stce_pkg;

  // command codes
  localparam logic [1:0] CMD_OPEN     = 2'd0;
  localparam logic [1:0] CMD_SEGMENT  = 2'd1;
  localparam logic [1:0] CMD_APP_DATA = 2'd2;
  localparam logic [1:0] CMD_CLOSE    = 2'd3;

  // segment flag bytes
  localparam logic [7:0] FL_NONE = 8'h00;
  localparam logic [7:0] FL_FIN  = 8'h01;
  localparam logic [7:0] FL_SYN  = 8'h02;
  localparam logic [7:0] FL_ACK  = 8'h10;

  // connection phases
  localparam logic [2:0] PH_CLOSED   = 3'd0;
  localparam logic [2:0] PH_LISTEN   = 3'd1;
  localparam logic [2:0] PH_SYN_SENT = 3'd2;
  localparam logic [2:0] PH_SYN_RCVD = 3'd3;
  localparam logic [2:0] PH_ESTAB    = 3'd4;
  localparam logic [2:0] PH_DONE     = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_LOCAL_ISN    = 2'd0;
  localparam logic [1:0] REG_ACTIVE_OPEN  = 2'd1;
  localparam logic [1:0] REG_LOCAL_WINDOW = 2'd2;

  localparam logic [31:0] RST_LOCAL_ISN = 32'd1;

  // fin count at which the close exchange is complete
  localparam logic [1:0] FIN_DONE_CNT = 2'd3;
  localparam logic [1:0] FIN_MAX      = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] seg_seq;
    logic [31:0] seg_ack;
    logic [7:0]  seg_flags;
    logic [15:0] seg_window;
    logic [3:0]  seg_header_words;
    logic [15:0] seg_total_len;
    logic [15:0] app_bytes_ready;
  } item_t;

  typedef struct packed {
    logic        send_valid;
    logic [7:0]  send_flags;
    logic [31:0] send_seq;
    logic [31:0] send_ack;
    logic [15:0] send_payload_len;
    logic [15:0] deliver_len;
    logic [15:0] deliver_skip;
    logic        peer_closed;
    logic        conn_done;
  } result_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [31:0] next_send_seq;
    logic [31:0] peer_acked_seq;
    logic [15:0] peer_window;
    logic [31:0] expected_recv_seq;
    logic [1:0]  fin_count;
  } conn_state_t;

  typedef struct packed {
    logic [31:0] local_isn;
    logic        active_open;
  } cfg_t;

endpackage

/* rtl/core/stce_if.sv */
`timescale 1ns / 1ps

interface stce_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] seg_seq;
  logic [31:0] seg_ack;
  logic [7:0]  seg_flags;
  logic [15:0] seg_window;
  logic [3:0]  seg_header_words;
  logic [15:0] seg_total_len;
  logic [15:0] app_bytes_ready;

  modport source (
    output valid, cmd, seg_seq, seg_ack, seg_flags, seg_window, seg_header_words,
           seg_total_len, app_bytes_ready,
    input  ready
  );
  modport sink (
    input  valid, cmd, seg_seq, seg_ack, seg_flags, seg_window, seg_header_words,
           seg_total_len, app_bytes_ready,
    output ready
  );
endinterface

interface stce_out_if;
  logic        valid;
  logic        ready;
  logic        send_valid;
  logic [7:0]  send_flags;
  logic [31:0] send_seq;
  logic [31:0] send_ack;
  logic [15:0] send_payload_len;
  logic [15:0] deliver_len;
  logic [15:0] deliver_skip;
  logic        peer_closed;
  logic        conn_done;

  modport source (
    output valid, send_valid, send_flags, send_seq, send_ack, send_payload_len,
           deliver_len, deliver_skip, peer_closed, conn_done,
    input  ready
  );
  modport sink (
    input  valid, send_valid, send_flags, send_seq, send_ack, send_payload_len,
           deliver_len, deliver_skip, peer_closed, conn_done,
    output ready
  );
endinterface

interface stce_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/stce_cfg_regs.sv */
`timescale 1ns / 1ps

module stce_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [31:0]        wr_data,
  output stce_pkg::cfg_t     cfg
);

  logic [31:0] local_isn_r;
  logic        active_open_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_isn_r   <= stce_pkg::RST_LOCAL_ISN;
      active_open_r <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        stce_pkg::REG_LOCAL_ISN: local_isn_r <= wr_data;
        stce_pkg::REG_ACTIVE_OPEN: active_open_r <= wr_data[0];
        // window only goes into the outgoing header, which is not emitted
        stce_pkg::REG_LOCAL_WINDOW: ;
        default: ;
      endcase
    end
  end

  assign cfg.local_isn   = local_isn_r;
  assign cfg.active_open = active_open_r;

endmodule

/* rtl/core/stce_event_logic.sv */
`timescale 1ns / 1ps

module stce_event_logic #(
  parameter logic [15:0] MAX_PAYLOAD = 16'd536
) (
  input  stce_pkg::cfg_t        cfg,
  input  stce_pkg::conn_state_t st,
  input  stce_pkg::item_t       item,
  output stce_pkg::conn_state_t st_nxt,
  output stce_pkg::result_t     res
);

  logic [1:0]         fin_bump;
  logic [31:0]        acked_max;
  logic [5:0]         hdr_bytes;
  logic               pay_pos;
  logic               pay_zero;
  logic [15:0]        plen;
  logic [31:0]        early;
  logic [31:0]        seq_end;
  logic [31:0]        new_ack;
  logic [31:0]        inflight;
  logic signed [33:0] room;
  logic               room_pos;
  logic [15:0]        room_c;
  logic [15:0]        n_send;

  always_comb begin
    fin_bump  = (st.fin_count == stce_pkg::FIN_MAX) ? stce_pkg::FIN_MAX
                                                   : st.fin_count + 2'd1;
    acked_max = (item.seg_ack > st.peer_acked_seq) ? item.seg_ack : st.peer_acked_seq;

    hdr_bytes = {item.seg_header_words, 2'b00};
    pay_pos   = item.seg_total_len > {10'd0, hdr_bytes};
    pay_zero  = item.seg_total_len == {10'd0, hdr_bytes};
    plen      = item.seg_total_len - {10'd0, hdr_bytes};
    early     = (st.expected_recv_seq > item.seg_seq) ?
                st.expected_recv_seq - item.seg_seq : 32'd0;
    seq_end   = item.seg_seq + {16'd0, plen};
    new_ack   = (seq_end > st.expected_recv_seq) ? seq_end : st.expected_recv_seq;

    // send room: peer window minus bytes in flight, in flight taken as signed
    inflight  = st.next_send_seq - st.peer_acked_seq;
    room      = $signed({18'd0, st.peer_window}) - $signed({{2{inflight[31]}}, inflight});
    room_pos  = room > 34'sd0;
    room_c    = (room > $signed({18'd0, MAX_PAYLOAD})) ? MAX_PAYLOAD : room[15:0];
    n_send    = (item.app_bytes_ready > room_c) ? room_c : item.app_bytes_ready;
  end

  always_comb begin
    st_nxt = st;
    res    = '0;
    case (st.phase)
      stce_pkg::PH_CLOSED: begin
        if (item.cmd == stce_pkg::CMD_OPEN) begin
          st_nxt.next_send_seq = cfg.local_isn;
          if (cfg.active_open) begin
            res.send_valid       = 1'b1;
            res.send_flags       = stce_pkg::FL_SYN;
            res.send_seq         = cfg.local_isn;
            st_nxt.next_send_seq = cfg.local_isn + 32'd1;
            st_nxt.phase         = stce_pkg::PH_SYN_SENT;
          end else begin
            st_nxt.phase = stce_pkg::PH_LISTEN;
          end
        end
      end
      stce_pkg::PH_LISTEN: begin
        if (item.cmd == stce_pkg::CMD_SEGMENT && item.seg_flags == stce_pkg::FL_SYN) begin
          st_nxt.expected_recv_seq = item.seg_seq + 32'd1;
          res.send_valid           = 1'b1;
          res.send_flags           = stce_pkg::FL_SYN | stce_pkg::FL_ACK;
          res.send_seq             = st.next_send_seq;
          res.send_ack             = item.seg_seq + 32'd1;
          st_nxt.next_send_seq     = st.next_send_seq + 32'd1;
          st_nxt.phase             = stce_pkg::PH_SYN_RCVD;
        end
      end
      stce_pkg::PH_SYN_SENT: begin
        if (item.cmd == stce_pkg::CMD_SEGMENT &&
            item.seg_flags == (stce_pkg::FL_SYN | stce_pkg::FL_ACK)) begin
          st_nxt.peer_acked_seq    = item.seg_ack;
          st_nxt.peer_window       = item.seg_window;
          st_nxt.expected_recv_seq = item.seg_seq + 32'd1;
          res.send_valid           = 1'b1;
          res.send_flags           = stce_pkg::FL_ACK;
          res.send_seq             = st.next_send_seq;
          res.send_ack             = item.seg_seq + 32'd1;
          st_nxt.phase             = stce_pkg::PH_ESTAB;
        end
      end
      stce_pkg::PH_SYN_RCVD: begin
        if (item.cmd == stce_pkg::CMD_SEGMENT && item.seg_flags == stce_pkg::FL_ACK) begin
          st_nxt.peer_acked_seq = item.seg_ack;
          st_nxt.peer_window    = item.seg_window;
          st_nxt.phase          = stce_pkg::PH_ESTAB;
        end
      end
      stce_pkg::PH_ESTAB: begin
        case (item.cmd)
          stce_pkg::CMD_SEGMENT: begin
            if (item.seg_flags == stce_pkg::FL_ACK && st.fin_count != 2'd0) begin
              // ACK during the close exchange
              st_nxt.fin_count      = fin_bump;
              st_nxt.peer_acked_seq = acked_max;
              if (fin_bump == stce_pkg::FIN_DONE_CNT) st_nxt.phase = stce_pkg::PH_DONE;
            end else if (item.seg_flags == stce_pkg::FL_FIN) begin
              st_nxt.fin_count = fin_bump;
              res.send_valid   = 1'b1;
              res.send_flags   = stce_pkg::FL_ACK;
              res.send_seq     = st.next_send_seq;
              res.send_ack     = st.expected_recv_seq;
              res.peer_closed  = 1'b1;
              if (fin_bump == stce_pkg::FIN_DONE_CNT) st_nxt.phase = stce_pkg::PH_DONE;
            end else begin
              if (item.seg_flags == stce_pkg::FL_ACK) begin
                st_nxt.peer_window    = item.seg_window;
                st_nxt.peer_acked_seq = acked_max;
              end
              // a pure ACK with no payload is not answered
              if (pay_pos || (pay_zero && item.seg_flags != stce_pkg::FL_ACK)) begin
                if ({16'd0, plen} > early) begin
                  res.deliver_len  = plen - early[15:0];
                  res.deliver_skip = early[15:0];
                end
                st_nxt.expected_recv_seq = new_ack;
                res.send_valid           = 1'b1;
                res.send_flags           = stce_pkg::FL_ACK;
                res.send_seq             = st.next_send_seq;
                res.send_ack             = new_ack;
              end
            end
          end
          stce_pkg::CMD_APP_DATA: begin
            if (room_pos && n_send != 16'd0) begin
              res.send_valid       = 1'b1;
              res.send_flags       = stce_pkg::FL_NONE;
              res.send_seq         = st.next_send_seq;
              res.send_ack         = st.expected_recv_seq;
              res.send_payload_len = n_send;
              st_nxt.next_send_seq = st.next_send_seq + {16'd0, n_send};
            end
          end
          stce_pkg::CMD_CLOSE: begin
            res.send_valid       = 1'b1;
            res.send_flags       = stce_pkg::FL_FIN;
            res.send_seq         = st.next_send_seq;
            res.send_ack         = st.expected_recv_seq;
            st_nxt.next_send_seq = st.next_send_seq + 32'd1;
            st_nxt.fin_count     = fin_bump;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    res.conn_done = st_nxt.phase >= stce_pkg::PH_DONE;
  end

endmodule

/* rtl/core/simple_tcp_connection_engine.sv */
`timescale 1ns / 1ps
// Channel  Modport  Handshake     Carries
// in_ch    sink     valid/ready   one event: cmd and arrived segment header fields
// out_ch   source   valid/ready   one result per event: send header, delivery, status
// cfg_ch   sink     valid/ready   register index and write data, ready while idle
//
// One event per cycle sustained while out_ch is not stalled; a result travels from its input beat
// through the input register, then combinational event logic, into the result register.
// The connection state registers update when an event moves into the result register.
// A stalled result holds the result register; the input register still takes a beat
// while the result register is full, then ready drops until the output drains.
// Synchronous active-low reset, no clearing pass; ready is low in reset, high right after.
// A cfg beat is taken only while neither register holds an event.
module simple_tcp_connection_engine #(
  parameter logic [15:0] MAX_PAYLOAD = 16'd536
) (
  input logic        clk,
  input logic        rst_n,
  stce_in_if.sink    in_ch,
  stce_out_if.source out_ch,
  stce_cfg_if.sink   cfg_ch
);

  stce_pkg::cfg_t        cfg;
  stce_pkg::conn_state_t st_r;
  stce_pkg::conn_state_t st_nxt;
  stce_pkg::item_t       in_item;
  stce_pkg::item_t       in_item_r;
  stce_pkg::result_t     res;
  stce_pkg::result_t     out_res_r;
  logic                  in_valid_r;
  logic                  in_valid_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic                  out_free;
  logic                  fire;
  logic                  in_take;

  assign cfg_ch.ready = rst_n && !in_valid_r && !out_valid_r;

  stce_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid && cfg_ch.ready),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  assign in_item.cmd              = in_ch.cmd;
  assign in_item.seg_seq          = in_ch.seg_seq;
  assign in_item.seg_ack          = in_ch.seg_ack;
  assign in_item.seg_flags        = in_ch.seg_flags;
  assign in_item.seg_window       = in_ch.seg_window;
  assign in_item.seg_header_words = in_ch.seg_header_words;
  assign in_item.seg_total_len    = in_ch.seg_total_len;
  assign in_item.app_bytes_ready  = in_ch.app_bytes_ready;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign fire        = in_valid_r && out_free;
  assign in_ch.ready = rst_n && (!in_valid_r || fire);
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    in_valid_nxt  = in_take || (in_valid_r && !fire);
    out_valid_nxt = fire || (out_valid_r && !out_ch.ready);
  end

  stce_event_logic #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_logic (
    .cfg    (cfg),
    .st     (st_r),
    .item   (in_item_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) in_item_r <= in_item;
    if (fire) out_res_r <= res;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.send_valid       = out_res_r.send_valid;
  assign out_ch.send_flags       = out_res_r.send_flags;
  assign out_ch.send_seq         = out_res_r.send_seq;
  assign out_ch.send_ack         = out_res_r.send_ack;
  assign out_ch.send_payload_len = out_res_r.send_payload_len;
  assign out_ch.deliver_len      = out_res_r.deliver_len;
  assign out_ch.deliver_skip     = out_res_r.deliver_skip;
  assign out_ch.peer_closed      = out_res_r.peer_closed;
  assign out_ch.conn_done        = out_res_r.conn_done;

endmodule

/* rtl/core/stce_checker.sv */
`timescale 1ns / 1ps
`include "simple_tcp_connection_engine_defines.svh"

module stce_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        send_valid,
  input logic [7:0]  send_flags,
  input logic [31:0] send_seq,
  input logic [31:0] send_ack,
  input logic [15:0] send_payload_len,
  input logic [15:0] deliver_len,
  input logic [15:0] deliver_skip
);

  logic stalled;
  logic hdr_clear;
  logic no_deliver;

  assign stalled    = out_valid && !out_ready;
  assign hdr_clear  = send_flags == 8'd0 && send_seq == 32'd0 && send_ack == 32'd0 &&
                      send_payload_len == 16'd0;
  assign no_deliver = out_valid && deliver_len == 16'd0;

  `STCE_ASSERT_NEXT(a_out_hold, stalled, out_valid, "result beat dropped while stalled")
  `STCE_ASSERT_NEXT(a_out_stable, stalled, $stable(send_seq) && $stable(send_ack), "beat moved")
  // header fields carry zeros when nothing is sent
  `STCE_ASSERT_NOW(a_idle_hdr, out_valid && !send_valid, hdr_clear, "header set without send")
  // skipped bytes are only reported alongside a nonzero delivery
  `STCE_ASSERT_NOW(a_skip_alone, no_deliver, deliver_skip == 16'd0, "skip without delivery")

endmodule

bind simple_tcp_connection_engine stce_checker u_stce_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .send_valid       (out_ch.send_valid),
  .send_flags       (out_ch.send_flags),
  .send_seq         (out_ch.send_seq),
  .send_ack         (out_ch.send_ack),
  .send_payload_len (out_ch.send_payload_len),
  .deliver_len      (out_ch.deliver_len),
  .deliver_skip     (out_ch.deliver_skip)
);
